@@ sv/path_dot_segment_normalizer_defines.svh @@
// ----------------------------------------------------------------------------
// Path dot-segment normalizer assertion macros
// Shared property forms for the concurrent checks of the normalizer.
// ----------------------------------------------------------------------------
`ifndef PATH_DOT_SEGMENT_NORMALIZER_DEFINES_SVH
`define PATH_DOT_SEGMENT_NORMALIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PDSN_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PDSN_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ sv/pdsn_pkg.sv @@
// ----------------------------------------------------------------------------
// Path dot-segment normalizer package
// Word types, buffer sizing, character codes and the back-end state type.
// ----------------------------------------------------------------------------
package pdsn_pkg;

  localparam int MAX_PATH_BYTES = 64;
  localparam int ADDR_W         = $clog2(MAX_PATH_BYTES);
  localparam int POS_W          = $clog2(MAX_PATH_BYTES + 1);

  // command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // result queue at the output
  localparam int ODEPTH  = 4;
  localparam int OPTR_W  = $clog2(ODEPTH);
  localparam int OCNT_W  = $clog2(ODEPTH + 1);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       path_end;
  } pdsn_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic       overflowed;
  } pdsn_out_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       abs_mode;
    logic       last;
    logic       add_slash;
  } pdsn_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PUT,
    BK_RD1,
    BK_RD2,
    BK_RD3,
    BK_SCAN,
    BK_NEXT,
    BK_EMIT
  } pdsn_bk_state_t;

endpackage

@@ sv/pdsn_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pdsn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/pdsn_front.sv @@
// ----------------------------------------------------------------------------
// Normalizer front end
// Accepts path words, marks absolute paths and queues commands for the back.
// ----------------------------------------------------------------------------
module pdsn_front
  import pdsn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  pdsn_in_t   item,
  output logic       cmd_valid,
  input  logic       cmd_pop,
  output pdsn_cmd_t  cmd
);

  logic              at_first;
  logic              is_abs;
  pdsn_cmd_t         q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic      accept;
  logic      abs_now;
  pdsn_cmd_t cmd_in;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign accept    = push && !full;

  // first word decides the path kind and is always stored plainly
  always_comb begin
    abs_now          = at_first ? (item.path_byte == CH_SLASH) : is_abs;
    cmd_in.ch        = item.path_byte;
    cmd_in.abs_mode  = !at_first && is_abs;
    cmd_in.last      = item.path_end;
    cmd_in.add_slash = item.path_end && abs_now && (item.path_byte != CH_SLASH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_first <= 1'b1;
      is_abs   <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      if (accept) begin
        q[wr_ptr] <= cmd_in;
        wr_ptr    <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
        at_first  <= item.path_end;
        is_abs    <= item.path_end ? 1'b0 : abs_now;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (accept && !cmd_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!accept && cmd_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ sv/pdsn_back.sv @@
// ----------------------------------------------------------------------------
// Normalizer back end
// Writes bytes into the path buffer, applies the dot-segment rules with
// buffer reads, and streams the finished path into the result queue.
// ----------------------------------------------------------------------------
module pdsn_back
  import pdsn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  input  pdsn_cmd_t cmd,
  output logic      empty,
  input  logic      pop,
  output pdsn_out_t result
);

  pdsn_bk_state_t    state, state_next;
  pdsn_cmd_t         cur, cur_next;
  logic [POS_W-1:0]  wp, wp_next;
  logic              ovf, ovf_next;
  logic              d1, d1_next;
  logic [ADDR_W-1:0] j, j_next;
  logic [POS_W-1:0]  k, k_next;
  logic              rd_pend;
  logic              pend_last;

  pdsn_out_t         oq [ODEPTH];
  logic [OPTR_W-1:0] owr_ptr;
  logic [OPTR_W-1:0] ord_ptr;
  logic [OCNT_W-1:0] ocount;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              issue;
  logic              space;
  logic              opop;

  pdsn_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PATH_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur.ch),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign empty     = (ocount == '0);
  assign result    = oq[ord_ptr];
  assign opop      = pop && !empty;
  assign ram_waddr = wp[ADDR_W-1:0];
  // leave room for the read still in flight
  assign space     = ({1'b0, ocount} + {{OCNT_W{1'b0}}, rd_pend}) < (OCNT_W + 1)'(ODEPTH);

  always_comb begin
    state_next = state;
    cur_next   = cur;
    wp_next    = wp;
    ovf_next   = ovf;
    d1_next    = d1;
    j_next     = j;
    k_next     = k;
    cmd_pop    = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = '0;
    issue      = 1'b0;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          cur_next   = cmd;
          state_next = BK_PUT;
        end
      end
      BK_PUT: begin
        if (wp >= POS_W'(MAX_PATH_BYTES)) begin
          // drop the byte
          ovf_next   = 1'b1;
          state_next = BK_NEXT;
        end else begin
          ram_we = 1'b1;
          if (!cur.abs_mode || cur.ch != CH_SLASH || wp == '0) begin
            wp_next    = wp + POS_W'(1);
            state_next = BK_NEXT;
          end else begin
            ram_raddr  = ADDR_W'(wp - POS_W'(1));
            state_next = BK_RD1;
          end
        end
      end
      BK_RD1: begin
        if (ram_rdata == CH_SLASH) begin
          // fold the double slash: hold the position
          state_next = BK_NEXT;
        end else begin
          d1_next = (ram_rdata == CH_DOT);
          if (wp >= POS_W'(2)) begin
            ram_raddr  = ADDR_W'(wp - POS_W'(2));
            state_next = BK_RD2;
          end else begin
            wp_next    = wp + POS_W'(1);
            state_next = BK_NEXT;
          end
        end
      end
      BK_RD2: begin
        if (d1 && ram_rdata == CH_SLASH) begin
          wp_next    = wp - POS_W'(1);
          state_next = BK_NEXT;
        end else if (d1 && ram_rdata == CH_DOT && wp >= POS_W'(3)) begin
          ram_raddr  = ADDR_W'(wp - POS_W'(3));
          state_next = BK_RD3;
        end else begin
          wp_next    = wp + POS_W'(1);
          state_next = BK_NEXT;
        end
      end
      BK_RD3: begin
        if (ram_rdata == CH_SLASH) begin
          if (wp >= POS_W'(5)) begin
            j_next     = ADDR_W'(wp - POS_W'(4));
            ram_raddr  = ADDR_W'(wp - POS_W'(4));
            state_next = BK_SCAN;
          end else begin
            // rewind clamps at the root
            wp_next    = POS_W'(1);
            state_next = BK_NEXT;
          end
        end else begin
          wp_next    = wp + POS_W'(1);
          state_next = BK_NEXT;
        end
      end
      BK_SCAN: begin
        if (ram_rdata == CH_SLASH) begin
          wp_next    = POS_W'(j) + POS_W'(1);
          state_next = BK_NEXT;
        end else if (j == ADDR_W'(1)) begin
          wp_next    = POS_W'(1);
          state_next = BK_NEXT;
        end else begin
          j_next    = j - ADDR_W'(1);
          ram_raddr = j - ADDR_W'(1);
        end
      end
      BK_NEXT: begin
        if (cur.last && cur.add_slash) begin
          cur_next.ch        = CH_SLASH;
          cur_next.abs_mode  = 1'b1;
          cur_next.add_slash = 1'b0;
          state_next         = BK_PUT;
        end else if (cur.last) begin
          k_next     = '0;
          state_next = BK_EMIT;
        end else begin
          state_next = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (k != wp) begin
          if (space) begin
            ram_raddr = k[ADDR_W-1:0];
            issue     = 1'b1;
            k_next    = k + POS_W'(1);
          end
        end else if (!rd_pend) begin
          wp_next    = '0;
          ovf_next   = 1'b0;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    d1  <= d1_next;
    j   <= j_next;
    k   <= k_next;
    if (rst) begin
      wp        <= '0;
      ovf       <= 1'b0;
      rd_pend   <= 1'b0;
      pend_last <= 1'b0;
      owr_ptr   <= '0;
      ord_ptr   <= '0;
      ocount    <= '0;
    end else begin
      wp        <= wp_next;
      ovf       <= ovf_next;
      rd_pend   <= issue;
      pend_last <= issue && (k + POS_W'(1) == wp);
      if (rd_pend) begin
        oq[owr_ptr].out_byte   <= ram_rdata;
        oq[owr_ptr].out_end    <= pend_last;
        oq[owr_ptr].overflowed <= ovf;
        owr_ptr <= (owr_ptr == OPTR_W'(ODEPTH - 1)) ? '0 : owr_ptr + OPTR_W'(1);
      end
      if (opop) begin
        ord_ptr <= (ord_ptr == OPTR_W'(ODEPTH - 1)) ? '0 : ord_ptr + OPTR_W'(1);
      end
      if (rd_pend && !opop) begin
        ocount <= ocount + OCNT_W'(1);
      end else if (!rd_pend && opop) begin
        ocount <= ocount - OCNT_W'(1);
      end
    end
  end

endmodule

@@ sv/path_dot_segment_normalizer.sv @@
// ----------------------------------------------------------------------------
// Path dot-segment normalizer
// Canonicalizes absolute paths ('//', '/./', '/../', trailing '/') and echoes
// relative paths, one byte per word in and out.
// ----------------------------------------------------------------------------
// Input channel: write a word (path_byte, path_end) with push while full is
// low; path_end marks the last byte of a path. Result channel: while empty
// is low the oldest result word is on result; pop takes it. out_end marks
// the last byte of a normalized path, overflowed is set on every word of a
// path longer than the 64-byte buffer (the result is then truncated).
// In the back end each byte is written into the buffer; a '/' of an absolute
// path then has the buffer read back for the dot patterns, and a '..' rewind
// also scans the buffer back byte by byte to the previous '/'. These reads
// share the single read port of the path buffer. After the last byte, the
// path streams out at one word per cycle while the result queue has room.
// A two-word command queue lets input be taken while the back end
// works. When the receiver stalls, the four-word result queue fills,
// streaming holds, and then full rises. Reset empties both queues and
// restarts at the first byte of a path; the buffer needs no clearing.
// ----------------------------------------------------------------------------
`include "path_dot_segment_normalizer_defines.svh"

module path_dot_segment_normalizer
  import pdsn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  pdsn_in_t  item,
  output logic      empty,
  input  logic      pop,
  output pdsn_out_t result
);

  logic      cmd_valid;
  logic      cmd_pop;
  pdsn_cmd_t cmd;

  pdsn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  pdsn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  `PDSN_ASSERT_NOW(a_pop_nonempty, cmd_pop, cmd_valid, "back end popped an empty queue")
  `PDSN_ASSERT_NEXT(a_cmd_held, cmd_valid && !cmd_pop, cmd_valid, "queued command lost")
  `PDSN_ASSERT_NEXT(a_push_queued, push && !full, cmd_valid, "accepted word not queued")

endmodule
